### design/rbe_pkg.sv
// rbe_pkg: shared types and constants for the rotated box extent pipeline.
// Holds the request/result structs, CORDIC pipeline structs and the
// arctangent table. No dependencies.
`default_nettype none

package rbe_pkg;

  localparam int ANGLE_BITS           = 16;
  localparam int LENGTH_FRACTION_BITS = 8;
  localparam int LEN_W                = 23;
  localparam int EXT_W                = 16;

  localparam int CORDIC_STEPS = 20;
  localparam int TRIG_W       = 32;  // signed Q2.30
  localparam int TRIG_FRAC    = 30;

  localparam int PROD_W      = LEN_W + TRIG_W;
  localparam int ROUND_SHIFT = TRIG_FRAC + LENGTH_FRACTION_BITS;
  localparam int MAG_W       = PROD_W - ROUND_SHIFT;

  // prep + CORDIC stages + abs, multiply, round + output register
  localparam int LATENCY = CORDIC_STEPS + 5;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) as 32-bit binary angles
  localparam logic [TRIG_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

  typedef struct packed {
    logic [LEN_W-1:0] half_diagonal;
    logic [15:0]      first_diagonal_angle;
    logic [15:0]      second_diagonal_angle;
    logic [15:0]      rotation_angle;
  } rbe_in_t;

  typedef struct packed {
    logic [EXT_W-1:0] box_width;
    logic [EXT_W-1:0] box_height;
  } rbe_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } rbe_lane_t;

  // one CORDIC stage: two diagonals in parallel, length rides along
  typedef struct packed {
    logic                valid;
    logic [LEN_W-1:0]    len;
    rbe_lane_t [1:0]     lane;
  } rbe_cordic_t;

  // rounded coordinate magnitudes: x0, y0, x1, y1
  typedef struct packed {
    logic                  valid;
    logic [3:0][MAG_W-1:0] mag;
  } rbe_mag_t;

endpackage

`default_nettype wire

### design/rbe_cordic_stage.sv
// rbe_cordic_stage: one registered rotation-mode CORDIC iteration, two lanes.
// Depends on rbe_pkg.
`default_nettype none

module rbe_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rbe_pkg::rbe_cordic_t stage_in,
  output rbe_pkg::rbe_cordic_t stage_out
);
  import rbe_pkg::*;

  localparam logic signed [TRIG_W-1:0] ATAN = $signed(ATAN_TABLE[STEP]);

  rbe_cordic_t stage_nxt;
  rbe_cordic_t stage_r;
  logic        valid_r;

  always_comb begin
    stage_nxt = stage_in;
    for (int l = 0; l < 2; l++) begin
      // floor shifts, direction from the sign of the residual angle
      if (!stage_in.lane[l].z[TRIG_W-1]) begin
        stage_nxt.lane[l].x = stage_in.lane[l].x - ($signed(stage_in.lane[l].y) >>> STEP);
        stage_nxt.lane[l].y = stage_in.lane[l].y + ($signed(stage_in.lane[l].x) >>> STEP);
        stage_nxt.lane[l].z = stage_in.lane[l].z - ATAN;
      end else begin
        stage_nxt.lane[l].x = stage_in.lane[l].x + ($signed(stage_in.lane[l].y) >>> STEP);
        stage_nxt.lane[l].y = stage_in.lane[l].y - ($signed(stage_in.lane[l].x) >>> STEP);
        stage_nxt.lane[l].z = stage_in.lane[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  always_comb begin
    stage_out       = stage_r;
    stage_out.valid = valid_r;
  end

endmodule

`default_nettype wire

### design/rbe_scale.sv
// rbe_scale: magnitude, length multiply and round-half-away for four coordinates.
// Three register stages. Depends on rbe_pkg.
`default_nettype none

module rbe_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbe_pkg::rbe_cordic_t scale_in,
  output rbe_pkg::rbe_mag_t    scale_out
);
  import rbe_pkg::*;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

  logic [3:0][TRIG_W-1:0] abs_nxt;
  logic [3:0][TRIG_W-1:0] abs_r;
  logic [LEN_W-1:0]       len_r;
  logic [3:0][PROD_W-1:0] prod_nxt;
  logic [3:0][PROD_W-1:0] prod_r;
  logic [3:0][PROD_W-1:0] sum_nxt;
  logic [3:0][MAG_W-1:0]  mag_r;
  logic                   valid_a_r;
  logic                   valid_b_r;
  logic                   valid_c_r;
  logic signed [3:0][TRIG_W-1:0] coord;

  // symmetric rounding: only the magnitude matters downstream
  always_comb begin
    coord[0] = scale_in.lane[0].x;
    coord[1] = scale_in.lane[0].y;
    coord[2] = scale_in.lane[1].x;
    coord[3] = scale_in.lane[1].y;
    for (int k = 0; k < 4; k++) begin
      abs_nxt[k] = coord[k][TRIG_W-1] ? TRIG_W'(-coord[k]) : TRIG_W'(coord[k]);
      prod_nxt[k] = PROD_W'(len_r) * PROD_W'(abs_r[k]);
      sum_nxt[k]  = prod_r[k] + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else begin
      valid_a_r <= scale_in.valid;
      valid_b_r <= valid_a_r;
      valid_c_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    abs_r  <= abs_nxt;
    len_r  <= scale_in.len;
    prod_r <= prod_nxt;
    for (int k = 0; k < 4; k++) begin
      mag_r[k] <= sum_nxt[k][PROD_W-1:ROUND_SHIFT];
    end
  end

  assign scale_out.valid = valid_c_r;
  assign scale_out.mag   = mag_r;

endmodule

`default_nettype wire

### design/rotated_box_extent_top.sv
// rotated_box_extent_top: axis-aligned box size of a rotated rectangle.
// A request passes prep, CORDIC, scale and output registers; one request per cycle.
// busy stays low: the pipeline never stalls and the receiver cannot stall it.
// The CORDIC pipeline has 20 stages, one iteration per stage.
// Synchronous active-low reset clears all valid bits; payload registers keep no reset.
// Depends on rbe_pkg, rbe_cordic_stage, rbe_scale.
`default_nettype none

module rotated_box_extent_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rbe_pkg::rbe_in_t  in_data,
  output logic              out_strobe,
  output rbe_pkg::rbe_out_t out_data
);
  import rbe_pkg::*;

  // ---------------------------------------------------------------------------
  // Angle prep.
  // The opposite endpoint of each diagonal (angle plus half a turn) gives
  // exactly the negated CORDIC result, so only two diagonals are rotated and
  // each extent is twice the larger rounded magnitude.
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [ANGLE_BITS-1:0] ang0;
  logic [ANGLE_BITS-1:0] ang1;
  logic [TRIG_W-1:0]     wide0;
  logic [TRIG_W-1:0]     wide1;
  logic [TRIG_W-1:0]     fold0;
  logic [TRIG_W-1:0]     fold1;

  rbe_cordic_t prep_nxt;
  rbe_cordic_t prep_r;
  logic        prep_valid_r;
  rbe_cordic_t chain [CORDIC_STEPS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    ang0  = in_data.first_diagonal_angle[ANGLE_BITS-1:0]
          + in_data.rotation_angle[ANGLE_BITS-1:0];
    ang1  = in_data.second_diagonal_angle[ANGLE_BITS-1:0]
          + in_data.rotation_angle[ANGLE_BITS-1:0];
    wide0 = TRIG_W'(ang0) << (TRIG_W - ANGLE_BITS);
    wide1 = TRIG_W'(ang1) << (TRIG_W - ANGLE_BITS);
    // fold the back half-plane forward; the sign flip drops out in the magnitude
    fold0 = wide0 ^ {wide0[TRIG_W-1] ^ wide0[TRIG_W-2], {(TRIG_W-1){1'b0}}};
    fold1 = wide1 ^ {wide1[TRIG_W-1] ^ wide1[TRIG_W-2], {(TRIG_W-1){1'b0}}};

    prep_nxt           = '0;
    prep_nxt.valid     = accept;
    prep_nxt.len       = in_data.half_diagonal;
    prep_nxt.lane[0].x = CORDIC_GAIN;
    prep_nxt.lane[0].y = '0;
    prep_nxt.lane[0].z = $signed(fold0);
    prep_nxt.lane[1].x = CORDIC_GAIN;
    prep_nxt.lane[1].y = '0;
    prep_nxt.lane[1].z = $signed(fold1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else begin
      prep_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

  always_comb begin
    chain[0]       = prep_r;
    chain[0].valid = prep_valid_r;
  end

  // ---------------------------------------------------------------------------
  // CORDIC pipeline: one iteration per register stage.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    rbe_cordic_stage #(
      .STEP (g)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Scale by length and round (three stages).
  // ---------------------------------------------------------------------------
  rbe_mag_t mags;

  rbe_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale_in  (chain[CORDIC_STEPS]),
    .scale_out (mags)
  );

  // ---------------------------------------------------------------------------
  // Extent: max - min of {r0, -r0, r1, -r1} = 2 * max(r0, r1), mod 2^16.
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] max_x;
  logic [MAG_W-1:0] max_y;
  rbe_out_t         out_nxt;
  rbe_out_t         out_r;
  logic             out_strobe_r;

  always_comb begin
    max_x = (mags.mag[0] > mags.mag[2]) ? mags.mag[0] : mags.mag[2];
    max_y = (mags.mag[1] > mags.mag[3]) ? mags.mag[1] : mags.mag[3];
    out_nxt.box_width  = EXT_W'({max_x, 1'b0});
    out_nxt.box_height = EXT_W'({max_y, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mags.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

### design/rbe_checker.sv
// rbe_checker: port-level assertions for rotated_box_extent_top, plus its bind.
// Depends on rbe_pkg.
`default_nettype none

module rbe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input rbe_pkg::rbe_out_t out_data
);
  import rbe_pkg::*;

  // every accepted request yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("missing result after accepted request");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_strobe)
    else $error("result without request");

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // symmetric endpoints make both extents even
  a_even_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!out_data.box_width[0] && !out_data.box_height[0]))
    else $error("odd extent");

endmodule

bind rotated_box_extent_top rbe_checker u_rbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
